// ----- sv/ppwl_pkg.sv -----
// Shared types and constants for the parallel port word link.
package ppwl_pkg;

    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 8;
    localparam int DATA_W  = 8;
    localparam int CTRL_W  = 4;
    localparam int BTO_W   = 20;
    localparam int TO_W    = 22;
    localparam int PHASE_W = 3;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;
    localparam int NIB_W   = 4;

    // Transfer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SEND_WAIT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEND_NEXT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RECV_WAIT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RECV_SAMPLE = 3'd4;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_IDLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WORD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RECV = 2'd3;

    // Control port values and status bit positions.
    localparam logic [CTRL_W-1:0] CTRL_STROBE  = 4'h5;
    localparam logic [CTRL_W-1:0] CTRL_RELEASE = 4'h4;
    localparam int                BUSY_BIT     = 3;
    localparam int                NIB_LSB      = 4;

    localparam logic [IDX_W-1:0] LAST_SEND_IDX = 3'd3;
    localparam logic [IDX_W-1:0] LAST_RECV_IDX = 3'd7;

    // Register indexes.
    localparam logic [1:0] REG_BYTE_TO = 2'd0;
    localparam logic [1:0] REG_SEND_TO = 2'd1;
    localparam logic [1:0] REG_RECV_TO = 2'd2;

    localparam logic [BTO_W-1:0] BYTE_TO_RST = 20'd50;
    localparam logic [TO_W-1:0]  SEND_TO_RST = 22'd2000000;
    localparam logic [TO_W-1:0]  RECV_TO_RST = 22'd100000;

    typedef struct packed {
        logic [BTO_W-1:0] byte_timeout;
        logic [TO_W-1:0]  send_timeout;
        logic [TO_W-1:0]  recv_timeout;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] data_pins;
        logic [CTRL_W-1:0] ctrl_pins;
        logic              engine_busy;
        logic              done_res;
        logic              error;
        logic [WORD_W-1:0] word_out;
    } t_result;

endpackage

// ----- sv/ppwl_cfg.sv -----
// Configuration registers of the parallel port word link behind an APB-style port.
module ppwl_cfg
    import ppwl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [BTO_W-1:0] r_byte_to;
    logic [TO_W-1:0]  r_send_to;
    logic [TO_W-1:0]  r_recv_to;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_to <= BYTE_TO_RST;
            r_send_to <= SEND_TO_RST;
            r_recv_to <= RECV_TO_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BYTE_TO: r_byte_to <= pwdata[BTO_W-1:0];
                REG_SEND_TO: r_send_to <= pwdata[TO_W-1:0];
                REG_RECV_TO: r_recv_to <= pwdata[TO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BYTE_TO: prdata = {{(APB_W-BTO_W){1'b0}}, r_byte_to};
            REG_SEND_TO: prdata = {{(APB_W-TO_W){1'b0}}, r_send_to};
            REG_RECV_TO: prdata = {{(APB_W-TO_W){1'b0}}, r_recv_to};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.byte_timeout = r_byte_to;
    assign o_cfg.send_timeout = r_send_to;
    assign o_cfg.recv_timeout = r_recv_to;

endmodule

// ----- sv/ppwl_core.sv -----
// Transfer state machine: advances the link by one tick per step.
module ppwl_core
    import ppwl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_word_in,
    input  logic [STAT_W-1:0] i_status_pins,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [IDX_W-1:0]   r_index, n_index;
    logic [WORD_W-1:0]  r_shift, n_shift;
    logic [TO_W-1:0]    r_wait, n_wait;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [CTRL_W-1:0]  r_ctrl, n_ctrl;
    logic [CMD_W-1:0]   r_op, n_op;

    logic              line_busy;
    logic              timed_out;
    logic              done;
    logic              err;
    logic [WORD_W-1:0] word_res;
    logic [NIB_W-1:0]  nib;
    logic [TO_W-1:0]   op_timeout;

    assign line_busy = i_status_pins[BUSY_BIT];
    assign timed_out = (r_wait <= TO_W'(1));
    assign nib       = i_status_pins[NIB_LSB +: NIB_W] ^ 4'b1000;

    // Per-element timeout of the transfer in progress.
    always_comb begin
        if (r_op == CMD_BYTE) begin
            op_timeout = {{(TO_W-BTO_W){1'b0}}, i_cfg.byte_timeout};
        end else if (r_op == CMD_WORD) begin
            op_timeout = i_cfg.send_timeout;
        end else begin
            op_timeout = i_cfg.recv_timeout;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_index  = r_index;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_data   = r_data;
        n_ctrl   = r_ctrl;
        n_op     = r_op;
        done     = 1'b0;
        err      = 1'b0;
        word_res = '0;
        unique case (r_phase)
            PH_SEND_WAIT: begin
                if (!line_busy) begin
                    n_ctrl = CTRL_RELEASE;
                    if (r_op != CMD_WORD || r_index >= LAST_SEND_IDX) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_index = r_index + IDX_W'(1);
                        n_shift = r_shift >> DATA_W;
                        n_phase = PH_SEND_NEXT;
                    end
                end else if (timed_out) begin
                    n_ctrl  = CTRL_RELEASE;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    err     = 1'b1;
                end else begin
                    n_wait = r_wait - TO_W'(1);
                end
            end
            PH_SEND_NEXT: begin
                n_data  = r_shift[DATA_W-1:0];
                n_ctrl  = CTRL_STROBE;
                n_wait  = op_timeout;
                n_phase = PH_SEND_WAIT;
            end
            PH_RECV_WAIT: begin
                if (!line_busy) begin
                    n_ctrl  = CTRL_STROBE;
                    n_phase = PH_RECV_SAMPLE;
                end else if (timed_out) begin
                    n_ctrl  = CTRL_RELEASE;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    err     = 1'b1;
                end else begin
                    n_wait = r_wait - TO_W'(1);
                end
            end
            PH_RECV_SAMPLE: begin
                n_shift = r_shift | ({{(WORD_W-NIB_W){1'b0}}, nib} << {r_index, 2'b00});
                n_ctrl  = CTRL_RELEASE;
                if (r_index >= LAST_RECV_IDX) begin
                    n_phase  = PH_IDLE;
                    done     = 1'b1;
                    word_res = n_shift;
                end else begin
                    n_index = r_index + IDX_W'(1);
                    n_wait  = i_cfg.recv_timeout;
                    n_phase = PH_RECV_WAIT;
                end
            end
            default: begin
                // Idle, and any code that means nothing, takes a new command.
                n_phase = PH_IDLE;
                case (i_command)
                    CMD_BYTE: begin
                        n_op    = CMD_BYTE;
                        n_index = '0;
                        n_shift = {{(WORD_W-DATA_W){1'b0}}, i_word_in[DATA_W-1:0]};
                        n_data  = i_word_in[DATA_W-1:0];
                        n_ctrl  = CTRL_STROBE;
                        n_wait  = {{(TO_W-BTO_W){1'b0}}, i_cfg.byte_timeout};
                        n_phase = PH_SEND_WAIT;
                    end
                    CMD_WORD: begin
                        n_op    = CMD_WORD;
                        n_index = '0;
                        n_shift = i_word_in;
                        n_data  = i_word_in[DATA_W-1:0];
                        n_ctrl  = CTRL_STROBE;
                        n_wait  = i_cfg.send_timeout;
                        n_phase = PH_SEND_WAIT;
                    end
                    CMD_RECV: begin
                        n_op    = CMD_RECV;
                        n_index = '0;
                        n_shift = '0;
                        n_ctrl  = CTRL_RELEASE;
                        n_wait  = i_cfg.recv_timeout;
                        n_phase = PH_RECV_WAIT;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_index <= '0;
            r_shift <= '0;
            r_wait  <= '0;
            r_data  <= '0;
            r_ctrl  <= CTRL_RELEASE;
            r_op    <= CMD_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_index <= n_index;
            r_shift <= n_shift;
            r_wait  <= n_wait;
            r_data  <= n_data;
            r_ctrl  <= n_ctrl;
            r_op    <= n_op;
        end
    end

    assign o_res.data_pins   = n_data;
    assign o_res.ctrl_pins   = n_ctrl;
    assign o_res.engine_busy = (n_phase != PH_IDLE);
    assign o_res.done_res    = done;
    assign o_res.error       = err;
    assign o_res.word_out    = word_res;

endmodule

// ----- sv/parallel_port_word_link_unit.sv -----
// Top level of the parallel port word link: input register, tick engine, result register.
// Each accepted transaction is one clock tick of the link: a command with the sampled status
// pins, answered by exactly one result transaction with the pin values and completion flags.
// A new tick is accepted every clock cycle while the result side is not stalled; its result is
// offered once the tick has moved from the input register into the result register. The only
// per-tick work is one pass through the transfer state machine, and a stalled result holds back
// the input side through the input register. The user must write timeout registers only while
// no tick is in flight; the block itself does not enforce this.
module parallel_port_word_link_unit
    import ppwl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_word_in,
    input  logic [STAT_W-1:0] i_status_pins,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_data_pins,
    output logic [CTRL_W-1:0] o_ctrl_pins,
    output logic              o_engine_busy,
    output logic              o_done_res,
    output logic              o_error,
    output logic [WORD_W-1:0] o_word_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_result step_res;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_command;
    logic [WORD_W-1:0] r_word_in;
    logic [STAT_W-1:0] r_status;
    logic              r_out_valid;
    t_result           r_res;
    logic              advance;
    logic              in_take;

    // The held tick moves on when the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    ppwl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppwl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_command     (r_command),
        .i_word_in     (r_word_in),
        .i_status_pins (r_status),
        .i_cfg         (cfg),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command <= i_command;
            r_word_in <= i_word_in;
            r_status  <= i_status_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_pins   = r_res.data_pins;
    assign o_ctrl_pins   = r_res.ctrl_pins;
    assign o_engine_busy = r_res.engine_busy;
    assign o_done_res    = r_res.done_res;
    assign o_error       = r_res.error;
    assign o_word_out    = r_res.word_out;

endmodule
